/* rtl/sbfd_pkg.sv */
// Package for the SBUS frame decoder: frame constants, state codes,
// control struct between sequencer and frame buffer. No dependencies.
package sbfd_pkg;

   localparam logic [7:0] START_BYTE     = 8'h0F;
   localparam logic [7:0] END_BYTE       = 8'h00;
   localparam int         CHAN_BYTES     = 22;
   localparam int         DATA_LEN       = 23;
   localparam int         NUM_CHANNELS   = 16;
   localparam int         RAW_W          = 11;
   localparam int         CHAN_BITS      = CHAN_BYTES * 8;
   localparam int         VALUE_W        = 12;
   localparam int         POS_W          = 5;
   localparam int         CHAN_IDX_W     = 4;

   localparam logic [RAW_W-1:0]   RAW_MASK      = 11'h7FF;
   localparam logic [VALUE_W-1:0] STICK_CENTER  = 12'd992;
   localparam logic [RAW_W-1:0]   SCALE_STEP1   = 11'd783;
   localparam logic [RAW_W-1:0]   SCALE_STEP2   = 11'd1566;
   localparam logic [VALUE_W-1:0] SCALE_POS     = 12'd800;
   localparam logic [VALUE_W-1:0] SCALE_NEG     = 12'hCE0;  // -800
   localparam logic [VALUE_W-1:0] SCALE_ZERO    = 12'd0;
   localparam logic [7:0]         FAILSAFE_MASK = 8'h08;
   localparam logic [7:0]         LOST_MASK     = 8'h04;

   localparam logic [POS_W-1:0]      LAST_CHAN_BYTE_POS = POS_W'(CHAN_BYTES - 1);
   localparam logic [POS_W-1:0]      FLAG_POS           = POS_W'(DATA_LEN - 1);
   localparam logic [POS_W-1:0]      END_POS            = POS_W'(DATA_LEN);
   localparam logic [CHAN_IDX_W-1:0] LAST_CHAN          = CHAN_IDX_W'(NUM_CHANNELS - 1);
   localparam logic [CHAN_IDX_W-1:0] OFFSET_LAST_CHAN   = 4'd9;

   typedef enum logic [2:0] {
      ST_HUNT    = 3'b001,
      ST_COLLECT = 3'b010,
      ST_EMIT    = 3'b100
   } state_type;

   typedef struct packed {
      logic push_byte;   // shift a channel byte into the buffer
      logic push_flag;   // capture the flag byte
      logic advance;     // drop the lowest channel field
   } buf_ctl_type;

endpackage

/* rtl/sbfd_if.sv */
// Valid/ready channel interfaces for the SBUS frame decoder.
// Depends on nothing; widths match sbfd_pkg.
interface sbfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sbfd_rsp_if;
   logic               valid;
   logic               ready;
   logic [3:0]         channel_index;
   logic signed [11:0] channel_value;
   logic               last_channel;
   logic               failsafe_flag;
   logic               lost_flag;
   modport source (output valid, output channel_index, output channel_value,
                   output last_channel, output failsafe_flag, output lost_flag,
                   input ready);
   modport sink   (input valid, input channel_index, input channel_value,
                   input last_channel, input failsafe_flag, input lost_flag,
                   output ready);
endinterface

/* rtl/sbfd_frame_buf.sv */
// Frame buffer: 22 channel bytes as one LSB-first shift line plus the flag byte.
// Depends on sbfd_pkg.
module sbfd_frame_buf (
   input  logic                           clock,
   input  sbfd_pkg::buf_ctl_type          ctl,
   input  logic [7:0]                     data_byte,
   output logic [sbfd_pkg::RAW_W-1:0]     raw_chan,
   output logic [7:0]                     flag_byte
);
   logic [sbfd_pkg::CHAN_BITS-1:0] bits_ff, bits_in;
   logic [7:0]                     flag_ff, flag_in;

   // New bytes enter at the top, so after 22 pushes byte 0 sits at bit 0.
   always_comb begin
      bits_in = bits_ff;
      flag_in = flag_ff;
      if (ctl.push_byte) begin
         bits_in = {data_byte, bits_ff[sbfd_pkg::CHAN_BITS-1:8]};
      end else if (ctl.advance) begin
         bits_in = bits_ff >> sbfd_pkg::RAW_W;
      end
      if (ctl.push_flag) begin
         flag_in = data_byte;
      end
   end

   always_ff @(posedge clock) begin
      bits_ff <= bits_in;
      flag_ff <= flag_in;
   end

   assign raw_chan  = bits_ff[sbfd_pkg::RAW_W-1:0];
   assign flag_byte = flag_ff;
endmodule

/* rtl/sbfd_chan_unit.sv */
// Shared channel decode unit: offset, scaling or pass-through per channel.
// Depends on sbfd_pkg.
module sbfd_chan_unit (
   input  logic [sbfd_pkg::CHAN_IDX_W-1:0]   chan,
   input  logic [sbfd_pkg::RAW_W-1:0]        raw,
   output logic signed [sbfd_pkg::VALUE_W-1:0] value
);
   logic [sbfd_pkg::VALUE_W-1:0] raw_ext;

   assign raw_ext = {1'b0, raw & sbfd_pkg::RAW_MASK};

   // Channel 0: (raw / 783) * 800 - 800 is one of three levels.
   always_comb begin
      priority if (chan == '0) begin
         priority if (raw >= sbfd_pkg::SCALE_STEP2) value = sbfd_pkg::SCALE_POS;
         else if (raw >= sbfd_pkg::SCALE_STEP1)     value = sbfd_pkg::SCALE_ZERO;
         else                                       value = sbfd_pkg::SCALE_NEG;
      end else if (chan <= sbfd_pkg::OFFSET_LAST_CHAN) begin
         value = raw_ext - sbfd_pkg::STICK_CENTER;
      end else begin
         value = raw_ext;
      end
   end
endmodule

/* rtl/sbus_frame_decoder.sv */
// SBUS frame decoder top level: byte sequencer, frame buffer, decode unit,
// output register. Depends on sbfd_pkg, sbfd_if, sbfd_frame_buf, sbfd_chan_unit.

// Takes one received serial byte per req item and hunts for the start byte
// 0x0F; the next 22 bytes are channel data, then a flag byte, then the end
// byte. A byte is taken whenever req_chan.ready is high. A zero end byte
// releases sixteen rsp items, channel 0 to 15 in order, one per cycle while
// rsp_chan.ready is held high; the burst is paced by the single decode unit,
// which handles one channel per cycle as the buffer shifts the next 11-bit
// field down. req_chan.ready is low during that burst and comes back as the
// last channel enters the output register. Channel 0 reads -800, 0 or 800,
// channels 1 to 9 are offset by -992, channels 10 to 15 are raw. Each item
// carries the failsafe (0x08) and frame-lost (0x04) bits of the flag byte.
// A nonzero end byte drops the frame silently and hunting resumes; the end
// byte never starts a frame. A 0x0F inside a frame is plain data.
module sbus_frame_decoder (
   input  logic        clock,
   input  logic        reset,
   sbfd_req_if.sink    req_chan,
   sbfd_rsp_if.source  rsp_chan
);
   sbfd_pkg::state_type                state_ff, state_in;
   logic [sbfd_pkg::POS_W-1:0]         pos_ff, pos_in;
   logic [sbfd_pkg::CHAN_IDX_W-1:0]    chan_ff, chan_in;
   sbfd_pkg::buf_ctl_type              buf_ctl;
   logic [sbfd_pkg::RAW_W-1:0]         raw_chan;
   logic [7:0]                         flag_byte;
   logic signed [sbfd_pkg::VALUE_W-1:0] dec_value;

   // Output register
   logic                                out_valid_ff, out_valid_in;
   logic [sbfd_pkg::CHAN_IDX_W-1:0]     out_idx_ff, out_idx_in;
   logic signed [sbfd_pkg::VALUE_W-1:0] out_val_ff, out_val_in;
   logic                                out_last_ff, out_last_in;
   logic                                out_fs_ff, out_fs_in;
   logic                                out_lost_ff, out_lost_in;

   logic req_take;
   logic out_free;
   logic emit_now;

   assign req_chan.ready = (state_ff != sbfd_pkg::ST_EMIT);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign emit_now       = (state_ff == sbfd_pkg::ST_EMIT) && out_free;

   sbfd_frame_buf u_buf (
      .clock     (clock),
      .ctl       (buf_ctl),
      .data_byte (req_chan.rx_byte),
      .raw_chan  (raw_chan),
      .flag_byte (flag_byte)
   );

   sbfd_chan_unit u_unit (
      .chan  (chan_ff),
      .raw   (raw_chan),
      .value (dec_value)
   );

   // Sequencer
   always_comb begin
      state_in          = state_ff;
      pos_in            = pos_ff;
      chan_in           = chan_ff;
      buf_ctl.push_byte = 1'b0;
      buf_ctl.push_flag = 1'b0;
      buf_ctl.advance   = 1'b0;
      unique case (state_ff)
         sbfd_pkg::ST_HUNT: begin
            if (req_take && req_chan.rx_byte == sbfd_pkg::START_BYTE) begin
               state_in = sbfd_pkg::ST_COLLECT;
               pos_in   = '0;
            end
         end
         sbfd_pkg::ST_COLLECT: begin
            if (req_take) begin
               priority if (pos_ff <= sbfd_pkg::LAST_CHAN_BYTE_POS) begin
                  buf_ctl.push_byte = 1'b1;
                  pos_in            = pos_ff + 1'b1;
               end else if (pos_ff == sbfd_pkg::FLAG_POS) begin
                  buf_ctl.push_flag = 1'b1;
                  pos_in            = pos_ff + 1'b1;
               end else begin
                  // end byte
                  pos_in = '0;
                  if (req_chan.rx_byte == sbfd_pkg::END_BYTE) begin
                     state_in = sbfd_pkg::ST_EMIT;
                     chan_in  = '0;
                  end else begin
                     state_in = sbfd_pkg::ST_HUNT;
                  end
               end
            end
         end
         sbfd_pkg::ST_EMIT: begin
            if (out_free) begin
               buf_ctl.advance = 1'b1;
               chan_in         = chan_ff + 1'b1;
               if (chan_ff == sbfd_pkg::LAST_CHAN) begin
                  state_in = sbfd_pkg::ST_HUNT;
               end
            end
         end
         default: begin
            state_in = sbfd_pkg::ST_HUNT;
         end
      endcase
   end

   // Output register load: a new channel replaces a taken one in the same cycle.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_idx_in   = out_idx_ff;
      out_val_in   = out_val_ff;
      out_last_in  = out_last_ff;
      out_fs_in    = out_fs_ff;
      out_lost_in  = out_lost_ff;
      if (emit_now) begin
         out_valid_in = 1'b1;
         out_idx_in   = chan_ff;
         out_val_in   = dec_value;
         out_last_in  = (chan_ff == sbfd_pkg::LAST_CHAN);
         out_fs_in    = |(flag_byte & sbfd_pkg::FAILSAFE_MASK);
         out_lost_in  = |(flag_byte & sbfd_pkg::LOST_MASK);
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sbfd_pkg::ST_HUNT;
         pos_ff       <= '0;
         chan_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         chan_ff      <= chan_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_idx_ff  <= out_idx_in;
      out_val_ff  <= out_val_in;
      out_last_ff <= out_last_in;
      out_fs_ff   <= out_fs_in;
      out_lost_ff <= out_lost_in;
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.channel_index = out_idx_ff;
   assign rsp_chan.channel_value = out_val_ff;
   assign rsp_chan.last_channel  = out_last_ff;
   assign rsp_chan.failsafe_flag = out_fs_ff;
   assign rsp_chan.lost_flag     = out_lost_ff;
endmodule

/* rtl/sbfd_checker.sv */
// Port-level checks for the SBUS frame decoder, bound to the top level.
// Depends on sbfd_pkg and sbus_frame_decoder.
module sbfd_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [sbfd_pkg::CHAN_IDX_W-1:0] rsp_index,
   input logic [sbfd_pkg::VALUE_W-1:0]  rsp_value,
   input logic                          rsp_last
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_index) && $stable(rsp_value))
      else $error("rsp item changed while stalled");

   a_burst_next: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=>
         rsp_valid && rsp_index == sbfd_pkg::CHAN_IDX_W'($past(rsp_index) + 1'b1))
      else $error("channel burst broke before the last channel");

   a_busy_in_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("byte taken in the middle of a channel burst");

   a_last_is_15: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_index == sbfd_pkg::LAST_CHAN)))
      else $error("last flag does not match the final channel");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");
endmodule

bind sbus_frame_decoder sbfd_checker u_sbfd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_index (rsp_chan.channel_index),
   .rsp_value (rsp_chan.channel_value),
   .rsp_last  (rsp_chan.last_channel)
);
